/* rtl/ckspb_pkg.sv */
// Shared types and constants for the color-keyed sprite blitter.
package ckspb_pkg;

  localparam int PIX_W      = 16;
  localparam int OFFSET_W   = 19;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 12;
  localparam int ALIGN_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // Screen coordinates before clipping; holds every reachable row and column.
  localparam int COORD_W    = 14;

  localparam logic [PIX_W-1:0]   KEY_RESET  = 16'h07E0;
  localparam logic [ALIGN_W-1:0] ALIGN_LEFT = 2'd0;
  localparam logic [ALIGN_W-1:0] ALIGN_MID  = 2'd1;
  localparam logic [ALIGN_W-1:0] ALIGN_END  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_WIDTH  = 3'd0,
    CFG_SPRITE_HEIGHT = 3'd1,
    CFG_DEST_X        = 3'd2,
    CFG_DEST_Y        = 3'd3,
    CFG_ALIGN_MODE    = 3'd4,
    CFG_KEY_COLOR     = 3'd5
  } cfg_idx_t;

  // Derived blit geometry handed from the register file to the scan logic.
  typedef struct packed {
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic signed [COORD_W-1:0] left_col;
    logic signed [COORD_W-1:0] top_row;
    logic [PIX_W-1:0]          key_color;
  } geom_t;

  // One pixel in flight between the input stage and the output register.
  typedef struct packed {
    logic [PIX_W-1:0]          pixel;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic                      opaque;
  } pix_stage_t;

endpackage

/* rtl/ckspb_in_if.sv */
// Source pixel channel.
interface ckspb_in_if import ckspb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

/* rtl/ckspb_out_if.sv */
// Frame-buffer write channel.
interface ckspb_out_if import ckspb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] fb_offset;
  logic [PIX_W-1:0]    fb_pixel;

  modport source (output valid, output fb_offset, output fb_pixel, input ready);
  modport sink (input valid, input fb_offset, input fb_pixel, output ready);
endinterface

/* rtl/color_key_sprite_blitter_unit.sv */
// Color-keyed sprite blitter: one source pixel per transaction, one optional frame-buffer write.
// A pixel passes the input stage and then the output register before its write is offered.
// One pixel per cycle while out_wr is ready; input stage and output register hold one each.
// Transparent and off-screen pixels are dropped in the output stage and still advance the counters.
// Reset returns all blit registers to their defaults and clears counters and pipeline valids.
module color_key_sprite_blitter_unit import ckspb_pkg::*; #(
  parameter int SCREEN_WIDTH   = 640,
  parameter int SCREEN_HEIGHT  = 480,
  parameter int MAX_SPRITE_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ckspb_in_if.sink              in_pix,
  ckspb_out_if.source           out_wr
);

  geom_t                     geom;
  logic signed [COORD_W-1:0] col_pos;
  logic signed [COORD_W-1:0] row_pos;
  logic                      accept;
  logic                      take;
  logic                      s1_valid_r, s1_valid_nxt;
  pix_stage_t                s1_r;

  ckspb_cfg #(
    .MAX_SPRITE_DIM(MAX_SPRITE_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  ckspb_scan #(
    .MAX_SPRITE_DIM(MAX_SPRITE_DIM)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .advance (accept),
    .col_pos (col_pos),
    .row_pos (row_pos)
  );

  assign in_pix.ready = !s1_valid_r || take;
  assign accept       = in_pix.valid && in_pix.ready;
  assign s1_valid_nxt = accept || (s1_valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.pixel  <= in_pix.src_pixel;
      s1_r.col    <= col_pos;
      s1_r.row    <= row_pos;
      s1_r.opaque <= (in_pix.src_pixel != geom.key_color);
    end
  end

  ckspb_wr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_wr (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (s1_valid_r),
    .stage       (s1_r),
    .take        (take),
    .wr_valid    (out_wr.valid),
    .wr_ready    (out_wr.ready),
    .wr_offset   (out_wr.fb_offset),
    .wr_pixel    (out_wr.fb_pixel)
  );

endmodule

/* rtl/ckspb_cfg.sv */
// Blit register file with size clamping and horizontal alignment.
module ckspb_cfg import ckspb_pkg::*; #(
  parameter int MAX_SPRITE_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output geom_t                 geom
);

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [POS_W-1:0]   dest_x_r;
  logic [POS_W-1:0]   dest_y_r;
  logic [ALIGN_W-1:0] align_r;
  logic [PIX_W-1:0]   key_r;

  logic [DIM_W-1:0]          width_c;
  logic [DIM_W-1:0]          height_c;
  logic signed [COORD_W-1:0] shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      dest_x_r <= '0;
      dest_y_r <= '0;
      align_r  <= ALIGN_LEFT;
      key_r    <= KEY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPRITE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_SPRITE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_DEST_X:        dest_x_r <= cfg_wdata[POS_W-1:0];
        CFG_DEST_Y:        dest_y_r <= cfg_wdata[POS_W-1:0];
        CFG_ALIGN_MODE:    align_r  <= cfg_wdata[ALIGN_W-1:0];
        CFG_KEY_COLOR:     key_r    <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one; sizes above the limit saturate.
  always_comb begin
    if (width_r == '0) begin
      width_c = DIM_W'(1);
    end else if (32'(width_r) > MAX_SPRITE_DIM) begin
      width_c = DIM_W'(MAX_SPRITE_DIM);
    end else begin
      width_c = width_r;
    end
    if (height_r == '0) begin
      height_c = DIM_W'(1);
    end else if (32'(height_r) > MAX_SPRITE_DIM) begin
      height_c = DIM_W'(MAX_SPRITE_DIM);
    end else begin
      height_c = height_r;
    end
  end

  always_comb begin
    case (align_r)
      ALIGN_MID: shift = $signed({{(COORD_W-DIM_W+1){1'b0}}, width_c[DIM_W-1:1]});
      ALIGN_END: shift = $signed({{(COORD_W-DIM_W){1'b0}}, width_c});
      default:   shift = '0;
    endcase
  end

  assign geom.width     = width_c;
  assign geom.height    = height_c;
  assign geom.left_col  = COORD_W'($signed(dest_x_r)) - shift;
  assign geom.top_row   = COORD_W'($signed(dest_y_r))
                        + $signed({{(COORD_W-DIM_W){1'b0}}, height_c})
                        - COORD_W'(1);
  assign geom.key_color = key_r;

endmodule

/* rtl/ckspb_scan.sv */
// Column and row counters that map each source pixel to screen coordinates.
module ckspb_scan import ckspb_pkg::*; #(
  parameter int MAX_SPRITE_DIM = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  geom_t                     geom,
  input  logic                      advance,
  output logic signed [COORD_W-1:0] col_pos,
  output logic signed [COORD_W-1:0] row_pos
);

  // The clamped size never exceeds the 11-bit register range.
  localparam int DIM_CAP = (MAX_SPRITE_DIM < 2047) ? MAX_SPRITE_DIM : 2047;
  localparam int CNT_W   = $clog2(DIM_CAP);
  localparam int CMP_W   = DIM_W + 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             col_wrap;
  logic             row_wrap;

  assign col_wrap = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(geom.width);
  assign row_wrap = (CMP_W'(row_r) + CMP_W'(1)) >= CMP_W'(geom.height);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Rows arrive bottom-up, so the screen row counts down from the top row.
  assign col_pos = geom.left_col + $signed({{(COORD_W-CNT_W){1'b0}}, col_r});
  assign row_pos = geom.top_row - $signed({{(COORD_W-CNT_W){1'b0}}, row_r});

endmodule

/* rtl/ckspb_wr.sv */
// Screen clipping, offset computation and the frame-buffer write register.
module ckspb_wr import ckspb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                stage_valid,
  input  pix_stage_t          stage,
  output logic                take,
  output logic                wr_valid,
  input  logic                wr_ready,
  output logic [OFFSET_W-1:0] wr_offset,
  output logic [PIX_W-1:0]    wr_pixel
);

  logic                valid_r, valid_nxt;
  logic [OFFSET_W-1:0] offset_r;
  logic [PIX_W-1:0]    pixel_r;
  logic                on_screen;
  logic [31:0]         offset_full;

  assign on_screen = (stage.col >= 0) && (stage.col < $signed(COORD_W'(SCREEN_WIDTH))) &&
                     (stage.row >= 0) && (stage.row < $signed(COORD_W'(SCREEN_HEIGHT)));

  assign offset_full = 32'(stage.row[COORD_W-2:0]) * 32'(SCREEN_WIDTH)
                     + 32'(stage.col[COORD_W-2:0]);

  assign take      = !valid_r || wr_ready;
  assign valid_nxt = take ? (stage_valid && stage.opaque && on_screen) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      offset_r <= offset_full[OFFSET_W-1:0];
      pixel_r  <= stage.pixel;
    end
  end

  assign wr_valid  = valid_r;
  assign wr_offset = offset_r;
  assign wr_pixel  = pixel_r;

endmodule
